// ===== rtl/cma_pkg.sv =====
// shared types and constants for the centered moving average block
// no dependencies; used by every module in rtl/
package cma_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int HALF_BITS      = 7;
  localparam int MAX_HALF       = 64;
  localparam int HALF_RESET     = 4;
  localparam int SUM_BITS       = 24;
  localparam int MAG_BITS       = SUM_BITS - 1;
  localparam int SEEN_BITS      = 16;
  localparam int INDEX_BITS     = 15;
  localparam int MAX_LENGTH     = 32768;
  localparam int RING_DEPTH     = 128;
  localparam int RING_ADDR_BITS = $clog2(RING_DEPTH);
  localparam int COUNT_BITS     = 8;
  localparam int STEP_BITS      = $clog2(MAG_BITS);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [COUNT_BITS-1:0]      count;
    logic [INDEX_BITS-1:0]      index;
    logic                       last;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CHECK,
    F_SUB
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_e;

  function automatic logic [HALF_BITS-1:0] clamp_half(input logic [HALF_BITS-1:0] h);
    logic [HALF_BITS-1:0] r;
    r = h;
    if (h == '0) r = HALF_BITS'(1);
    else if (h > HALF_BITS'(MAX_HALF)) r = HALF_BITS'(MAX_HALF);
    return r;
  endfunction

endpackage

// ===== rtl/centered_moving_average.sv =====
// top level of the centered moving average: front, job queue and divider back
// depends on cma_pkg, cma_front, cma_queue, cma_back
//
//   channel   valid/stall                  payload
//   input     in_valid_i / in_stall_o      sample_i, last_i
//   output    out_valid_o / out_stall_i    average_o, index_o, last_out_o
//   config    half_window_we_i             half_window_i
//
// in the front a sample is taken, then checked; each output it releases adds
// a ring read with the job push, then a window sum update. each output then
// passes through the bit-serial divider, which sets the sustained rate. the
// queue holds 4 jobs so the front keeps taking samples while the divider or a
// stalled output holds back. reset clears all control state; the sample ring
// needs no clearing pass.
module centered_moving_average (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    half_window_we_i,
  input  logic [cma_pkg::HALF_BITS-1:0]           half_window_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [cma_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                    last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [cma_pkg::SAMPLE_BITS-1:0]  average_o,
  output logic [cma_pkg::INDEX_BITS-1:0]          index_o,
  output logic                                    last_out_o
);

  logic          push, full, pop, empty;
  cma_pkg::job_t push_data, pop_data;

  cma_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .half_window_we_i (half_window_we_i),
    .half_window_i    (half_window_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .last_i           (last_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .full_i           (full)
  );

  cma_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  cma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .average_o   (average_o),
    .index_o     (index_o),
    .last_out_o  (last_out_o)
  );

  // the front never overruns the job queue
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full)) else $error("job pushed into full queue");

  // the divider only takes a job that is there
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty)) else $error("job popped from empty queue");

  // an accepted sample keeps the front busy for the following cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("front took two samples back to back");

  // a job is never pushed in the cycle a sample is taken
  a_push_not_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> in_stall_o) else $error("job pushed while front idle");

endmodule

// ===== rtl/cma_front.sv =====
// front part: takes samples, keeps the sample ring and running window sum,
// and issues one averaging job per output; uses cma_pkg
module cma_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 half_window_we_i,
  input  logic [cma_pkg::HALF_BITS-1:0]        half_window_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [cma_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                 last_i,
  output logic                                 push_o,
  output cma_pkg::job_t                        push_data_o,
  input  logic                                 full_i
);

  cma_pkg::front_state_e state_q, state_d;

  logic [cma_pkg::HALF_BITS-1:0]   half_q;
  logic [cma_pkg::HALF_BITS-1:0]   p_q, p_d;
  logic signed [cma_pkg::SUM_BITS-1:0] sum_q, sum_d;
  logic [cma_pkg::SEEN_BITS-1:0]   seen_q, seen_d;
  logic [cma_pkg::SEEN_BITS-1:0]   next_q, next_d;
  logic                            last_q, last_d;
  logic                            sub_en_q, sub_en_d;

  logic signed [cma_pkg::SAMPLE_BITS-1:0] ring [cma_pkg::RING_DEPTH];
  logic signed [cma_pkg::SAMPLE_BITS-1:0] rd_data_q;
  logic [cma_pkg::RING_ADDR_BITS-1:0]     rd_addr;

  logic                            accept;
  logic                            pending;
  logic [cma_pkg::SEEN_BITS:0]     next_plus_p;
  logic [cma_pkg::SEEN_BITS-1:0]   p_ext;
  logic [cma_pkg::SEEN_BITS-1:0]   lo;
  logic [cma_pkg::SEEN_BITS-1:0]   cnt_full;

  assign accept      = in_valid_i && (state_q == cma_pkg::F_IDLE);
  assign in_stall_o  = (state_q != cma_pkg::F_IDLE);
  assign p_ext       = cma_pkg::SEEN_BITS'(p_q);
  assign next_plus_p = {1'b0, next_q} + {1'b0, p_ext};
  assign pending     = last_q ? (next_q < seen_q)
                              : (next_plus_p <= {1'b0, seen_q});
  assign lo          = (next_q >= p_ext) ? (next_q - p_ext) : '0;
  assign cnt_full    = seen_q - lo;
  assign rd_addr     = cma_pkg::RING_ADDR_BITS'(next_q - p_ext);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cma_pkg::F_IDLE: begin
        if (accept) state_d = cma_pkg::F_CHECK;
      end
      cma_pkg::F_CHECK: begin
        if (pending) begin
          if (!full_i) state_d = cma_pkg::F_SUB;
        end else begin
          state_d = cma_pkg::F_IDLE;
        end
      end
      cma_pkg::F_SUB: state_d = cma_pkg::F_CHECK;
      default: state_d = cma_pkg::F_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    p_d         = p_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    next_d      = next_q;
    last_d      = last_q;
    sub_en_d    = sub_en_q;
    push_o      = 1'b0;
    push_data_o.sum   = sum_q;
    push_data_o.count = cma_pkg::COUNT_BITS'(cnt_full);
    push_data_o.index = cma_pkg::INDEX_BITS'(next_q);
    push_data_o.last  = last_q && ((next_q + 1'b1) == seen_q);
    case (state_q)
      cma_pkg::F_IDLE: begin
        if (accept) begin
          // a new stream latches the half window and starts from an empty sum
          if (seen_q == '0) begin
            p_d   = cma_pkg::clamp_half(half_q);
            sum_d = cma_pkg::SUM_BITS'(sample_i);
          end else begin
            sum_d = sum_q + cma_pkg::SUM_BITS'(sample_i);
          end
          seen_d = seen_q + 1'b1;
          last_d = last_i || (seen_q >= cma_pkg::SEEN_BITS'(cma_pkg::MAX_LENGTH - 1));
        end
      end
      cma_pkg::F_CHECK: begin
        if (pending) begin
          if (!full_i) begin
            push_o   = 1'b1;
            sub_en_d = (next_q >= p_ext);
            next_d   = next_q + 1'b1;
          end
        end else if (last_q) begin
          sum_d  = '0;
          seen_d = '0;
          next_d = '0;
          last_d = 1'b0;
        end
      end
      cma_pkg::F_SUB: begin
        // drop the sample that leaves the window
        if (sub_en_q) sum_d = sum_q - cma_pkg::SUM_BITS'(rd_data_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cma_pkg::F_IDLE;
      half_q   <= cma_pkg::HALF_BITS'(cma_pkg::HALF_RESET);
      p_q      <= cma_pkg::HALF_BITS'(cma_pkg::HALF_RESET);
      sum_q    <= '0;
      seen_q   <= '0;
      next_q   <= '0;
      last_q   <= 1'b0;
      sub_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (half_window_we_i) half_q <= half_window_i;
      p_q      <= p_d;
      sum_q    <= sum_d;
      seen_q   <= seen_d;
      next_q   <= next_d;
      last_q   <= last_d;
      sub_en_q <= sub_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ring[cma_pkg::RING_ADDR_BITS'(seen_q)] <= sample_i;
    rd_data_q <= ring[rd_addr];
  end

endmodule

// ===== rtl/cma_queue.sv =====
// short job queue between the front and the back part
// uses cma_pkg::job_t
module cma_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cma_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cma_pkg::job_t pop_data_o,
  output logic          empty_o
);

  cma_pkg::job_t                  mem_q [cma_pkg::QUEUE_DEPTH];
  logic [cma_pkg::QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [cma_pkg::QPTR_BITS:0]    fill_q, fill_d;

  assign full_o     = (fill_q == (cma_pkg::QPTR_BITS+1)'(cma_pkg::QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) fill_d = fill_q + 1'b1;
    else if (pop_i && !push_i) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/cma_back.sv =====
// back part: divides each job's window sum by its count, one quotient bit
// a cycle, and holds the result in the output register; uses cma_pkg
module cma_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    empty_i,
  input  cma_pkg::job_t                           job_i,
  output logic                                    pop_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [cma_pkg::SAMPLE_BITS-1:0]  average_o,
  output logic [cma_pkg::INDEX_BITS-1:0]          index_o,
  output logic                                    last_out_o
);

  cma_pkg::back_state_e state_q, state_d;

  logic [cma_pkg::MAG_BITS-1:0]    mag_q, mag_d;
  logic [cma_pkg::COUNT_BITS:0]    rem_q, rem_d;
  logic [cma_pkg::COUNT_BITS-1:0]  div_q, div_d;
  logic [cma_pkg::STEP_BITS-1:0]   step_q, step_d;
  logic                            neg_q, neg_d;
  logic [cma_pkg::INDEX_BITS-1:0]  idx_q, idx_d;
  logic                            fin_q, fin_d;

  logic                            out_valid_q;
  logic                            load_out;
  logic [cma_pkg::COUNT_BITS:0]    rem_shift;
  logic                            ge;
  logic [cma_pkg::SUM_BITS-1:0]    abs_sum;
  logic [cma_pkg::MAG_BITS-1:0]    signed_q;

  assign abs_sum   = job_i.sum[cma_pkg::SUM_BITS-1] ? -job_i.sum : job_i.sum;
  assign rem_shift = {rem_q[cma_pkg::COUNT_BITS-1:0], mag_q[cma_pkg::MAG_BITS-1]};
  assign ge        = (rem_shift >= {1'b0, div_q});
  assign signed_q  = neg_q ? -mag_q : mag_q;
  assign load_out  = (state_q == cma_pkg::B_HOLD) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cma_pkg::B_IDLE: if (!empty_i) state_d = cma_pkg::B_DIV;
      cma_pkg::B_DIV: begin
        if (step_q == cma_pkg::STEP_BITS'(cma_pkg::MAG_BITS - 1)) state_d = cma_pkg::B_HOLD;
      end
      cma_pkg::B_HOLD: if (load_out) state_d = cma_pkg::B_IDLE;
      default: state_d = cma_pkg::B_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    step_d = step_q;
    neg_d  = neg_q;
    idx_d  = idx_q;
    fin_d  = fin_q;
    pop_o  = 1'b0;
    case (state_q)
      cma_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          mag_d  = cma_pkg::MAG_BITS'(abs_sum);
          rem_d  = '0;
          div_d  = job_i.count;
          step_d = '0;
          neg_d  = job_i.sum[cma_pkg::SUM_BITS-1];
          idx_d  = job_i.index;
          fin_d  = job_i.last;
        end
      end
      cma_pkg::B_DIV: begin
        // restoring step, quotient bits shift in behind the dividend
        rem_d  = ge ? (rem_shift - {1'b0, div_q}) : rem_shift;
        mag_d  = {mag_q[cma_pkg::MAG_BITS-2:0], ge};
        step_d = step_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cma_pkg::B_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
    idx_q <= idx_d;
    fin_q <= fin_d;
    if (load_out) begin
      average_o  <= cma_pkg::SAMPLE_BITS'(signed_q);
      index_o    <= idx_q;
      last_out_o <= fin_q;
    end
  end

endmodule
